[rtl/tvs_pkg.sv]
`timescale 1ns / 1ps
package tvs_pkg;

  localparam int ROOT_W = 32;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  typedef struct packed {
    logic [31:0]        uniform_sample;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic signed [31:0] peak;
  } in_t;

  typedef struct packed {
    logic signed [31:0] variate;
    logic               invalid;
  } out_t;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               sel;
    logic               inv;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  xrest;
  } sq_t;

endpackage

[rtl/tvs_sqrt_cell.sv]
`timescale 1ns / 1ps
module tvs_sqrt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  tvs_pkg::sq_t   sq_in,
  input  tvs_pkg::side_t side_in,
  output logic          v_r,
  output tvs_pkg::sq_t   sq_r,
  output tvs_pkg::side_t side_r
);

  logic [tvs_pkg::REM_W-1:0] rem_sh;
  logic [tvs_pkg::REM_W-1:0] trial;
  logic                      ge;
  tvs_pkg::sq_t              sq_nxt;

  always_comb begin
    rem_sh = {sq_in.rem[tvs_pkg::ROOT_W-1:0], sq_in.xrest[tvs_pkg::RAD_W-1 -: 2]};
    trial  = {sq_in.root, 2'b01};
    ge     = (rem_sh >= trial);
    sq_nxt.rem   = ge ? (rem_sh - trial) : rem_sh;
    sq_nxt.root  = {sq_in.root[tvs_pkg::ROOT_W-2:0], ge};
    sq_nxt.xrest = {sq_in.xrest[tvs_pkg::RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r   <= sq_nxt;
      side_r <= side_in;
    end
  end

endmodule

[rtl/triangular_variate_sampler_unit.sv]
`timescale 1ns / 1ps
// Channel | Direction | Payload            | Handshake
// in_     | input     | tvs_pkg::in_t      | in_valid / in_ready
// out_    | output    | tvs_pkg::out_t     | out_valid / out_ready
// One item is accepted per cycle unless the output is stalled and every stage is full.
// The pipeline has an input register, five arithmetic stages, 32 square-root cells that
// each settle one bit of the root, and an output register.
// Reset clears all valid bits; the payload registers are not reset.
// A stall at the output holds only the stages that are full, so bubbles are squeezed out.
module triangular_variate_sampler_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tvs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tvs_pkg::out_t out_data
);

  localparam int NC = tvs_pkg::ROOT_W;

  logic [5:0]   v_r;
  logic [5:0]   en;
  logic [NC-1:0] vc;
  logic [NC-1:0] en_c;
  logic          en_o;
  logic          ov_r;

  tvs_pkg::in_t   p0_r;
  logic           inv1_r;
  logic [31:0]    d1_r, a1_r, b1_r, u1_r;
  logic signed [31:0] lo1_r, hi1_r;
  logic [63:0]    ud2_r, wd2_r;
  logic [31:0]    a2_r, b2_r;
  tvs_pkg::side_t sd2_r, sd3_r, sd4_r, sd5_r;
  logic [63:0]    p3_r;
  logic [31:0]    c3_r;
  logic [63:0]    phc4_r, plc4_r;
  logic [63:0]    rad5_r;
  logic [32:0]    w1;
  logic [65:0]    wd_full;
  tvs_pkg::sq_t   sq_in0;
  tvs_pkg::sq_t   sq_c  [NC];
  tvs_pkg::side_t sd_c  [NC];
  tvs_pkg::out_t  out_r;
  logic signed [33:0] r_ext;
  tvs_pkg::out_t  out_nxt;

  always_comb begin
    en_o = !ov_r || out_ready;
    en_c[NC-1] = !vc[NC-1] || en_o;
    for (int i = NC - 2; i >= 0; i--) begin
      en_c[i] = !vc[i] || en_c[i+1];
    end
    en[5] = !v_r[5] || en_c[0];
    for (int i = 4; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < 6; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign w1      = 33'h1_0000_0000 - {1'b0, u1_r};
  assign wd_full = w1 * {1'b0, d1_r};

  always_ff @(posedge clk) begin
    if (en[0]) p0_r <= in_data;
    if (en[1]) begin
      inv1_r <= (p0_r.lower_bound >= p0_r.upper_bound) || (p0_r.peak > p0_r.upper_bound)
                || (p0_r.lower_bound > p0_r.peak);
      d1_r   <= p0_r.upper_bound - p0_r.lower_bound;
      a1_r   <= p0_r.peak - p0_r.lower_bound;
      b1_r   <= p0_r.upper_bound - p0_r.peak;
      u1_r   <= p0_r.uniform_sample;
      lo1_r  <= p0_r.lower_bound;
      hi1_r  <= p0_r.upper_bound;
    end
    if (en[2]) begin
      ud2_r     <= 64'(u1_r) * 64'(d1_r);
      wd2_r     <= wd_full[63:0];
      a2_r      <= a1_r;
      b2_r      <= b1_r;
      sd2_r.lo  <= lo1_r;
      sd2_r.hi  <= hi1_r;
      sd2_r.sel <= 1'b0;
      sd2_r.inv <= inv1_r;
    end
    if (en[3]) begin
      sd3_r.lo  <= sd2_r.lo;
      sd3_r.hi  <= sd2_r.hi;
      sd3_r.inv <= sd2_r.inv;
      sd3_r.sel <= (ud2_r < {a2_r, 32'h0});
      p3_r      <= (ud2_r < {a2_r, 32'h0}) ? ud2_r : wd2_r;
      c3_r      <= (ud2_r < {a2_r, 32'h0}) ? a2_r : b2_r;
    end
    if (en[4]) begin
      phc4_r <= 64'(p3_r[63:32]) * 64'(c3_r);
      plc4_r <= 64'(p3_r[31:0]) * 64'(c3_r);
      sd4_r  <= sd3_r;
    end
    if (en[5]) begin
      rad5_r <= phc4_r + {32'h0, plc4_r[63:32]};
      sd5_r  <= sd4_r;
    end
  end

  assign sq_in0.rem   = '0;
  assign sq_in0.root  = '0;
  assign sq_in0.xrest = rad5_r;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    if (g == 0) begin : g_first
      tvs_sqrt_cell u_cell (
        .clk(clk), .rst_n(rst_n), .en(en_c[g]), .v_in(v_r[5]),
        .sq_in(sq_in0), .side_in(sd5_r),
        .v_r(vc[g]), .sq_r(sq_c[g]), .side_r(sd_c[g])
      );
    end else begin : g_next
      tvs_sqrt_cell u_cell (
        .clk(clk), .rst_n(rst_n), .en(en_c[g]), .v_in(vc[g-1]),
        .sq_in(sq_c[g-1]), .side_in(sd_c[g-1]),
        .v_r(vc[g]), .sq_r(sq_c[g]), .side_r(sd_c[g])
      );
    end
  end

  always_comb begin
    if (sd_c[NC-1].sel) begin
      r_ext = {{2{sd_c[NC-1].lo[31]}}, sd_c[NC-1].lo} + $signed({2'b00, sq_c[NC-1].root});
    end else begin
      r_ext = {{2{sd_c[NC-1].hi[31]}}, sd_c[NC-1].hi} - $signed({2'b00, sq_c[NC-1].root});
    end
    if (sd_c[NC-1].inv) begin
      out_nxt.variate = '0;
    end else if (r_ext > 34'sh0_7FFF_FFFF) begin
      out_nxt.variate = 32'sh7FFF_FFFF;
    end else if (r_ext < -34'sh0_8000_0000) begin
      out_nxt.variate = 32'sh8000_0000;
    end else begin
      out_nxt.variate = r_ext[31:0];
    end
    out_nxt.invalid = sd_c[NC-1].inv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en_o) begin
      ov_r <= vc[NC-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) out_r <= out_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

[rtl/tvs_checker.sv]
`timescale 1ns / 1ps
module tvs_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input tvs_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input tvs_pkg::out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid |-> out_data.variate == 32'sd0)
    else $error("invalid result carries nonzero variate");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind triangular_variate_sampler_unit tvs_checker u_tvs_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

[verif/triangular_variate_sampler_checker.sv]
`timescale 1ns / 1ps
module triangular_variate_sampler_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  tvs_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  tvs_pkg::out_t out_data,
  output int            fail_count,
  output int            pending_count,
  output int            variate_count
);

  tvs_pkg::out_t expected_variates[$];

  function automatic logic [63:0] floor_sqrt(logic [63:0] radicand);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitpos;
    rem = radicand;
    root = '0;
    bitpos = 64'h1 << 62;
    while (bitpos > rem) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (rem >= root + bitpos) begin
        rem = rem - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root = root >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return root;
  endfunction

  function automatic tvs_pkg::out_t predict_variate(tvs_pkg::in_t item);
    logic signed [65:0] lo;
    logic signed [65:0] hi;
    logic signed [65:0] pk;
    logic signed [65:0] sum;
    logic [31:0] span;
    logic [31:0] left;
    logic [31:0] right;
    logic [127:0] prod;
    logic [63:0] scaled;
    logic [32:0] comp;
    tvs_pkg::out_t res;
    lo = item.lower_bound;
    hi = item.upper_bound;
    pk = item.peak;
    res = '0;
    if (lo >= hi || pk > hi || lo > pk) begin
      res.invalid = 1'b1;
      return res;
    end
    span = 32'(hi - lo);
    left = 32'(pk - lo);
    right = 32'(hi - pk);
    if ({32'h0, item.uniform_sample} * {32'h0, span} < {left, 32'h0}) begin
      prod = 128'(item.uniform_sample) * 128'(span) * 128'(left);
      scaled = 64'(prod >> 32);
      sum = lo + $signed({2'b00, floor_sqrt(scaled)});
    end else begin
      comp = 33'h1_0000_0000 - {1'b0, item.uniform_sample};
      prod = 128'(comp) * 128'(span) * 128'(right);
      scaled = 64'(prod >> 32);
      sum = hi - $signed({2'b00, floor_sqrt(scaled)});
    end
    if (sum > 66'sd2147483647) sum = 66'sd2147483647;
    if (sum < -66'sd2147483648) sum = -66'sd2147483648;
    res.variate = sum[31:0];
    return res;
  endfunction

  always_ff @(posedge clk) begin
    tvs_pkg::out_t want;
    if (!rst_n) begin
      fail_count <= 0;
      variate_count <= 0;
      expected_variates.delete();
    end else begin
      if (in_valid && in_ready) expected_variates.push_back(predict_variate(in_data));
      if (out_valid && out_ready) begin
        variate_count <= variate_count + 1;
        if (expected_variates.size() == 0) begin
          $display("%0t: unexpected transfer out, variate %0d invalid %0b",
                   $time, out_data.variate, out_data.invalid);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_variates.pop_front();
          if (want.variate !== out_data.variate || want.invalid !== out_data.invalid) begin
            $display("%0t: mismatch, expected variate %0d invalid %0b, got %0d invalid %0b",
                     $time, want.variate, want.invalid, out_data.variate, out_data.invalid);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending_count = expected_variates.size();
endmodule

[verif/triangular_variate_sampler_unit_tb.sv]
`timescale 1ns / 1ps
module triangular_variate_sampler_unit_tb;

  localparam int LATENCY = 38;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  tvs_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  tvs_pkg::out_t out_data;
  int   fail_count;
  int   pending_count;
  int   variate_count;
  int   cycle_count;
  int   sender_idle_pct;
  int   receiver_idle_pct;
  int   directed_count;

  triangular_variate_sampler_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  triangular_variate_sampler_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .variate_count(variate_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles.", cycle_count);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic send_sample(tvs_pkg::in_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_directed(logic [31:0] u, logic [31:0] lo, logic [31:0] hi,
                               logic [31:0] pk);
    tvs_pkg::in_t item;
    item.uniform_sample = u;
    item.lower_bound = lo;
    item.upper_bound = hi;
    item.peak = pk;
    send_sample(item);
    directed_count++;
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(2000)) - 1000);
      3: return 32'($signed($urandom_range(2000)) - 1000) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic tvs_pkg::in_t random_sample();
    tvs_pkg::in_t item;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] t;
    item.uniform_sample = ($urandom_range(9) == 0) ?
                          (($urandom_range(1) == 0) ? 32'h0 : 32'hFFFF_FFFF) : $urandom;
    w0 = random_word();
    w1 = random_word();
    w2 = random_word();
    if ($urandom_range(9) < 8) begin
      if ($signed(w0) > $signed(w1)) begin t = w0; w0 = w1; w1 = t; end
      if ($signed(w1) > $signed(w2)) begin t = w1; w1 = w2; w2 = t; end
      if ($signed(w0) > $signed(w1)) begin t = w0; w0 = w1; w1 = t; end
      if (w0 == w2) w2 = w2 + 1;
      if ($signed(w2) < $signed(w0)) begin w0 = w0 - 1; w1 = w0 + 1; w2 = w0 + 2; end
      item.lower_bound = w0;
      item.peak = ($urandom_range(7) == 0) ? w0 : (($urandom_range(7) == 0) ? w2 : w1);
      item.upper_bound = w2;
    end else begin
      item.lower_bound = w0;
      item.upper_bound = w1;
      item.peak = w2;
    end
    return item;
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    directed_count = 0;
    sender_idle_pct = 27;
    receiver_idle_pct = 52;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_directed(32'h0, 32'h0, 32'h0001_0000, 32'h0);
    send_directed(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
    send_directed(32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 32'h0001_0000);
    send_directed(32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 32'h0);
    send_directed(32'h8000_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0);
    send_directed(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_directed(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_directed(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_directed(32'h4000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
    send_directed(32'h1234_5678, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_directed(32'h0000_0001, 32'h0, 32'h0000_0001, 32'h0);
    send_directed(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_directed(32'h5555_5555, 32'h0002_0000, 32'h0001_0000, 32'h0001_8000);
    send_directed(32'h5555_5555, 32'h0, 32'h0001_0000, 32'h0002_0000);
    send_directed(32'h5555_5555, 32'h0001_0000, 32'h0003_0000, 32'h0);
    send_directed(32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_directed(32'hC000_0000, 32'hFFFE_0000, 32'hFFFF_0000, 32'hFFFE_8000);
    in_valid <= 1'b0;
    @(posedge clk);

    wait (pending_count == 0);
    repeat (5) @(posedge clk);
    repeat (180) send_sample(random_sample());
    sender_idle_pct = 52;
    receiver_idle_pct = 27;
    repeat (180) send_sample(random_sample());
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    repeat (180) send_sample(random_sample());
    in_valid <= 1'b0;
    @(posedge clk);

    wait (pending_count == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d directed and 540 random samples under three idle patterns;",
             directed_count);
    $display("%0d variates compared, covering both branches and inconsistent bounds.",
             variate_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
